/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check, switched off while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent check, live through reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* design/ber_hdr_pkg.sv */
package ber_hdr_pkg;

  localparam int unsigned NumFields = 8;
  localparam int unsigned FieldIdxW = $clog2(NumFields);

  // field slots in the store
  localparam logic [FieldIdxW-1:0] FieldVersion = FieldIdxW'(0);
  localparam logic [FieldIdxW-1:0] FieldFlow    = FieldIdxW'(2);
  localparam logic [FieldIdxW-1:0] FieldFlag    = FieldIdxW'(6);
  localparam logic [FieldIdxW-1:0] FieldLast    = FieldIdxW'(NumFields - 1);

  localparam logic [7:0] IntegerTag    = 8'd2;
  localparam logic [7:0] ShortFormMax  = 8'd128;
  localparam logic [7:0] MaxFieldBytes = 8'd4;

  localparam logic [31:0] MinVersionReset = 32'd0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDRLEN,
    PH_SKIP,
    PH_TAG,
    PH_LEN,
    PH_VAL
  } phase_e;

  typedef enum logic [3:0] {
    PS_OK            = 4'd0,
    PS_OLD_VERSION   = 4'd1,
    PS_BAD_HEADER    = 4'd2,
    PS_MISSING_SEQ   = 4'd3,
    PS_MISSING_FLOW  = 4'd4,
    PS_MISSING_PROTO = 4'd5,
    PS_MISSING_USER  = 4'd6,
    PS_MISSING_IP    = 4'd7,
    PS_MISSING_FLAG  = 4'd8,
    PS_MISSING_RET   = 4'd9,
    PS_OVERSIZE      = 4'd10
  } status_e;

  typedef struct packed {
    logic [31:0] version_value;
    logic [31:0] sequence_number;
    logic [7:0]  flow_offset;
    logic [31:0] flow_value;
    logic [31:0] protocol_number;
    logic [31:0] user_id;
    logic [31:0] ip_address;
    logic [31:0] flag_value;
    logic [31:0] return_code;
    status_e     parse_status;
  } result_t;

endpackage

/* design/ber_integer_header_parser_core.sv */
// Streaming decoder for a BER-style header of eight INTEGER fields (tag 2):
// version, sequence, flow, protocol, user id, ip, flag and return code.
// Feed one message byte per input beat, message_start_i high on byte 0.
// Byte 1 is the header length: 128 or less is short form, above that its
// low 7 bits count length octets that are skipped. Each field is tag,
// length (0..4) and big-endian value bytes; flag and return code are
// sign-extended from their length. One result beat is given when parsing
// ends: after the return code, on the first framing error, or when the
// version is below min_version (written through cfg_we_i/cfg_wdata_i; the
// user must do so only while idle, not enforced by the block). Fields not
// reached read as zero. Bytes after a result and before the next message
// start are dropped. Throughput is one byte per clock unless stalled: each
// byte updates the parse registers and a finishing byte loads the result
// register directly. A second result register acts as a skid stage, so a
// waiting result does not stall input; input stalls only when both are full.
`include "assert_macros.svh"

module ber_integer_header_parser_core #(
  parameter logic [31:0] MinVersionRst = ber_hdr_pkg::MinVersionReset
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               message_start_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        version_value_o,
  output logic [31:0]        sequence_number_o,
  output logic [7:0]         flow_offset_o,
  output logic [31:0]        flow_value_o,
  output logic [31:0]        protocol_number_o,
  output logic [31:0]        user_id_o,
  output logic [31:0]        ip_address_o,
  output logic signed [31:0] flag_value_o,
  output logic signed [31:0] return_code_o,
  output logic [3:0]         parse_status_o
);

  localparam int unsigned IdxW = ber_hdr_pkg::FieldIdxW;

  // parse state
  ber_hdr_pkg::phase_e  phase_q, phase_d;
  logic [IdxW-1:0]      fidx_q, fidx_d;
  logic [7:0]           offs_q, offs_d;
  logic [6:0]           left_q, left_d;     // skip or value bytes remaining
  logic [2:0]           flen_q, flen_d;
  logic                 long_q, long_d;
  logic [31:0]          acc_q, acc_d;
  logic [7:0]           flow_offs_q, flow_offs_d;
  logic [31:0]          store_q [ber_hdr_pkg::NumFields];
  logic [31:0]          store_d [ber_hdr_pkg::NumFields];
  logic [31:0]          min_version_q;

  // result path: output register plus skid
  ber_hdr_pkg::result_t out_q, skid_q, res;
  logic                 out_valid_q, skid_valid_q;

  logic                 in_acc, out_take;
  logic                 res_emit, finish;
  ber_hdr_pkg::status_e status;
  logic [31:0]          fval, fext;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_version_q <= MinVersionRst;
    end else if (cfg_we_i) begin
      min_version_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    fidx_d      = fidx_q;
    offs_d      = offs_q;
    left_d      = left_q;
    flen_d      = flen_q;
    long_d      = long_q;
    acc_d       = acc_q;
    flow_offs_d = flow_offs_q;
    store_d     = store_q;
    res_emit    = 1'b0;
    finish      = 1'b0;
    status      = ber_hdr_pkg::PS_OK;
    fval        = '0;
    fext        = '0;

    if (in_acc) begin
      if (message_start_i) begin
        // restart: byte 0 itself carries nothing
        phase_d     = ber_hdr_pkg::PH_HDRLEN;
        fidx_d      = '0;
        offs_d      = '0;
        left_d      = '0;
        flen_d      = '0;
        long_d      = 1'b0;
        acc_d       = '0;
        flow_offs_d = '0;
        store_d     = '{default: '0};
      end else if (phase_q != ber_hdr_pkg::PH_IDLE) begin
        offs_d = offs_q + 8'd1;
        case (phase_q)
          ber_hdr_pkg::PH_HDRLEN: begin
            if (data_byte_i <= ber_hdr_pkg::ShortFormMax) begin
              long_d  = 1'b0;
              phase_d = ber_hdr_pkg::PH_TAG;
            end else begin
              long_d  = 1'b1;
              left_d  = data_byte_i[6:0];
              phase_d = (data_byte_i[6:0] != 7'd0) ? ber_hdr_pkg::PH_SKIP
                                                   : ber_hdr_pkg::PH_TAG;
            end
          end
          ber_hdr_pkg::PH_SKIP: begin
            left_d = left_q - 7'd1;
            if (left_q == 7'd1) begin
              phase_d = ber_hdr_pkg::PH_TAG;
            end
          end
          ber_hdr_pkg::PH_TAG: begin
            if (data_byte_i == ber_hdr_pkg::IntegerTag) begin
              phase_d = ber_hdr_pkg::PH_LEN;
            end else begin
              res_emit = 1'b1;
              if (fidx_q == ber_hdr_pkg::FieldVersion) begin
                // long form: version tag check is folded into the sequence one
                status = long_q ? ber_hdr_pkg::PS_MISSING_SEQ
                                : ber_hdr_pkg::PS_BAD_HEADER;
              end else begin
                // missing codes run in field order from the sequence field
                status = ber_hdr_pkg::status_e'(4'(ber_hdr_pkg::PS_MISSING_SEQ)
                                                + 4'(fidx_q) - 4'd1);
              end
            end
          end
          ber_hdr_pkg::PH_LEN: begin
            if (data_byte_i > ber_hdr_pkg::MaxFieldBytes) begin
              res_emit = 1'b1;
              status   = ber_hdr_pkg::PS_OVERSIZE;
            end else begin
              flen_d = data_byte_i[2:0];
              acc_d  = '0;
              if (fidx_q == ber_hdr_pkg::FieldFlow) begin
                flow_offs_d = offs_q + 8'd2;
              end
              if (data_byte_i[2:0] == 3'd0) begin
                finish = 1'b1;
              end else begin
                left_d  = {4'd0, data_byte_i[2:0]};
                phase_d = ber_hdr_pkg::PH_VAL;
              end
            end
          end
          ber_hdr_pkg::PH_VAL: begin
            fval   = {acc_q[23:0], data_byte_i};
            acc_d  = fval;
            left_d = left_q - 7'd1;
            finish = (left_q == 7'd1);
          end
          default: begin
            phase_d = ber_hdr_pkg::PH_IDLE;
          end
        endcase

        if (finish) begin
          fext = fval;
          if (fidx_q >= ber_hdr_pkg::FieldFlag) begin
            case (flen_d)
              3'd1:    fext = {{24{fval[7]}}, fval[7:0]};
              3'd2:    fext = {{16{fval[15]}}, fval[15:0]};
              3'd3:    fext = {{8{fval[23]}}, fval[23:0]};
              default: fext = fval;
            endcase
          end
          store_d[fidx_q] = fext;
          if (fidx_q == ber_hdr_pkg::FieldVersion && fext < min_version_q) begin
            res_emit = 1'b1;
            status   = ber_hdr_pkg::PS_OLD_VERSION;
          end else if (fidx_q == ber_hdr_pkg::FieldLast) begin
            res_emit = 1'b1;
            status   = ber_hdr_pkg::PS_OK;
          end else begin
            fidx_d  = fidx_q + IdxW'(1);
            phase_d = ber_hdr_pkg::PH_TAG;
          end
        end

        if (res_emit) begin
          phase_d = ber_hdr_pkg::PH_IDLE;
        end
      end
    end
  end

  always_comb begin
    res.version_value   = store_d[0];
    res.sequence_number = store_d[1];
    res.flow_offset     = flow_offs_d;
    res.flow_value      = store_d[2];
    res.protocol_number = store_d[3];
    res.user_id         = store_d[4];
    res.ip_address      = store_d[5];
    res.flag_value      = store_d[6];
    res.return_code     = store_d[7];
    res.parse_status    = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ber_hdr_pkg::PH_IDLE;
      fidx_q  <= '0;
      offs_q  <= '0;
      left_q  <= '0;
      flen_q  <= '0;
      long_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      fidx_q  <= fidx_d;
      offs_q  <= offs_d;
      left_q  <= left_d;
      flen_q  <= flen_d;
      long_q  <= long_d;
    end
  end

  // payload, rewritten at every message start
  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    flow_offs_q <= flow_offs_d;
    store_q     <= store_d;
  end

  // result beats: output register, overflow into skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_emit) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_emit) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign version_value_o   = out_q.version_value;
  assign sequence_number_o = out_q.sequence_number;
  assign flow_offset_o     = out_q.flow_offset;
  assign flow_value_o      = out_q.flow_value;
  assign protocol_number_o = out_q.protocol_number;
  assign user_id_o         = out_q.user_id;
  assign ip_address_o      = out_q.ip_address;
  assign flag_value_o      = out_q.flag_value;
  assign return_code_o     = out_q.return_code;
  assign parse_status_o    = out_q.parse_status;

  `ASSERT_RST(a_skid_needs_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid full, output empty")
  `ASSERT_RST(a_skid_fill, clk_i, rst_ni, $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i), "skid filled with output free")
  `ASSERT_RST(a_no_idle_result, clk_i, rst_ni, res_emit |-> (phase_q != ber_hdr_pkg::PH_IDLE), "result while idle")
  `ASSERT_RST(a_skip_count, clk_i, rst_ni, (phase_q == ber_hdr_pkg::PH_SKIP) |-> (left_q != 7'd0), "skip phase with no bytes left")

endmodule

/* tb/tb.sv */
module tb;

  // Run limit, far above the slowest correct run, in which beats may sit
  // behind input gaps and output stalls.
  localparam int unsigned CycleLimit = 400000;
  // Cycles allowed for the parse and skid registers to empty out.
  localparam int unsigned SettleCycles = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [31:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         data_byte_i;
  logic               message_start_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [31:0]        version_value_o;
  logic [31:0]        sequence_number_o;
  logic [7:0]         flow_offset_o;
  logic [31:0]        flow_value_o;
  logic [31:0]        protocol_number_o;
  logic [31:0]        user_id_o;
  logic [31:0]        ip_address_o;
  logic signed [31:0] flag_value_o;
  logic signed [31:0] return_code_o;
  logic [3:0]         parse_status_o;

  ber_integer_header_parser_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .message_start_i   (message_start_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .version_value_o   (version_value_o),
    .sequence_number_o (sequence_number_o),
    .flow_offset_o     (flow_offset_o),
    .flow_value_o      (flow_value_o),
    .protocol_number_o (protocol_number_o),
    .user_id_o         (user_id_o),
    .ip_address_o      (ip_address_o),
    .flag_value_o      (flag_value_o),
    .return_code_o     (return_code_o),
    .parse_status_o    (parse_status_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder shadow: mirrors the parse state, updated on every accepted beat
  // ---------------------------------------------------------------------------
  ber_hdr_pkg::phase_e                hdr_phase;
  logic [ber_hdr_pkg::FieldIdxW-1:0]  field_sel;
  logic [7:0]                         byte_pos;
  logic [7:0]                         count_left;
  logic [2:0]                         value_len;
  logic                               long_hdr;
  logic [31:0]                        value_acc;
  logic [31:0]                        field_vals [ber_hdr_pkg::NumFields];
  logic [7:0]                         flow_hold;
  logic [31:0]                        min_version_model;

  ber_hdr_pkg::result_t decoded_headers_q[$];   // results still to come out, oldest first

  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned beats_sent;
  int unsigned settings_used;
  int unsigned cycle_count = 0;
  bit          gaps_on;

  function automatic void post_header(input ber_hdr_pkg::status_e status);
    ber_hdr_pkg::result_t hdr;
    hdr.version_value   = field_vals[0];
    hdr.sequence_number = field_vals[1];
    hdr.flow_offset     = flow_hold;
    hdr.flow_value      = field_vals[2];
    hdr.protocol_number = field_vals[3];
    hdr.user_id         = field_vals[4];
    hdr.ip_address      = field_vals[5];
    hdr.flag_value      = field_vals[6];
    hdr.return_code     = field_vals[7];
    hdr.parse_status    = status;
    decoded_headers_q = {decoded_headers_q, hdr};
    hdr_phase = ber_hdr_pkg::PH_IDLE;
  endfunction

  function automatic void close_field();
    logic [31:0] v;
    v = value_acc;
    // flag and return code are two's complement, widened from their length
    if (field_sel >= ber_hdr_pkg::FieldFlag) begin
      case (value_len)
        3'd1: v = {{24{v[7]}}, v[7:0]};
        3'd2: v = {{16{v[15]}}, v[15:0]};
        3'd3: v = {{8{v[23]}}, v[23:0]};
        default: ;
      endcase
    end
    field_vals[field_sel] = v;
    if (field_sel == ber_hdr_pkg::FieldVersion && v < min_version_model) begin
      post_header(ber_hdr_pkg::PS_OLD_VERSION);
    end else if (field_sel == ber_hdr_pkg::FieldLast) begin
      post_header(ber_hdr_pkg::PS_OK);
    end else begin
      field_sel = field_sel + 1'b1;
      hdr_phase = ber_hdr_pkg::PH_TAG;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic first);
    if (first) begin
      foreach (field_vals[i]) field_vals[i] = '0;
      field_sel  = ber_hdr_pkg::FieldVersion;
      byte_pos   = '0;
      count_left = '0;
      value_len  = '0;
      long_hdr   = 1'b0;
      value_acc  = '0;
      flow_hold  = '0;
      hdr_phase  = ber_hdr_pkg::PH_HDRLEN;
      return;
    end
    if (hdr_phase == ber_hdr_pkg::PH_IDLE) return;   // stray byte between messages
    byte_pos = byte_pos + 8'd1;
    case (hdr_phase)
      ber_hdr_pkg::PH_HDRLEN: begin
        if (b <= ber_hdr_pkg::ShortFormMax) begin
          long_hdr  = 1'b0;
          hdr_phase = ber_hdr_pkg::PH_TAG;
        end else begin
          long_hdr   = 1'b1;
          count_left = {1'b0, b[6:0]};
          hdr_phase  = (count_left != 0) ? ber_hdr_pkg::PH_SKIP : ber_hdr_pkg::PH_TAG;
        end
      end
      ber_hdr_pkg::PH_SKIP: begin
        count_left = count_left - 8'd1;
        if (count_left == 0) hdr_phase = ber_hdr_pkg::PH_TAG;
      end
      ber_hdr_pkg::PH_TAG: begin
        if (b == ber_hdr_pkg::IntegerTag) begin
          hdr_phase = ber_hdr_pkg::PH_LEN;
        end else if (field_sel == ber_hdr_pkg::FieldVersion) begin
          // long form skips straight past the version, so it reads as a missing sequence tag
          post_header(long_hdr ? ber_hdr_pkg::PS_MISSING_SEQ : ber_hdr_pkg::PS_BAD_HEADER);
        end else begin
          post_header(ber_hdr_pkg::status_e'(4'(ber_hdr_pkg::PS_MISSING_SEQ)
                                             + 4'(field_sel) - 4'd1));
        end
      end
      ber_hdr_pkg::PH_LEN: begin
        if (b > ber_hdr_pkg::MaxFieldBytes) begin
          post_header(ber_hdr_pkg::PS_OVERSIZE);
        end else begin
          value_len = b[2:0];
          value_acc = '0;
          if (field_sel == ber_hdr_pkg::FieldFlow) flow_hold = byte_pos + 8'd1;
          if (b == 0) begin
            close_field();
          end else begin
            count_left = b;
            hdr_phase  = ber_hdr_pkg::PH_VAL;
          end
        end
      end
      ber_hdr_pkg::PH_VAL: begin
        value_acc  = {value_acc[23:0], b};
        count_left = count_left - 8'd1;
        if (count_left == 0) close_field();
      end
      default: hdr_phase = ber_hdr_pkg::PH_IDLE;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, checks at the rising edge
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    if (!gaps_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    ber_hdr_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_headers_q.size() == 0) begin
        $display("%0t: result beat with none expected, status %h", $time, parse_status_o);
        mismatch_count++;
      end else begin
        want = decoded_headers_q.pop_front();
        check_field("version_value",   want.version_value,   version_value_o);
        check_field("sequence_number", want.sequence_number, sequence_number_o);
        check_field("flow_offset",     32'(want.flow_offset), 32'(flow_offset_o));
        check_field("flow_value",      want.flow_value,      flow_value_o);
        check_field("protocol_number", want.protocol_number, protocol_number_o);
        check_field("user_id",         want.user_id,         user_id_o);
        check_field("ip_address",      want.ip_address,      ip_address_o);
        check_field("flag_value",      want.flag_value,      flag_value_o);
        check_field("return_code",     want.return_code,     return_code_o);
        check_field("parse_status",    32'(want.parse_status), 32'(parse_status_o));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               decoded_headers_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------

  // One input beat; entered and left at a falling edge. Valid is left high
  // so back-to-back beats need no second assignment in one step.
  task automatic send_beat(input logic [7:0] value, input logic first);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= value;
    message_start_i <= first;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(value, first);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    while (decoded_headers_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register writes only with the byte side quiet and no result outstanding.
  task automatic set_min_version(input logic [31:0] value);
    in_valid_i <= 1'b0;
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i          <= 1'b0;
    min_version_model = value;
    settings_used++;
  endtask

  // Message under construction
  logic [7:0] frame_q[$];

  function automatic void frame_append(input logic [7:0] b);
    frame_q = {frame_q, b};
  endfunction

  task automatic frame_begin(input logic [7:0] hdr_len);
    int unsigned skip;
    skip = (hdr_len > ber_hdr_pkg::ShortFormMax) ? int'(hdr_len[6:0]) : 0;
    frame_q.delete();
    frame_append(8'($urandom));   // byte 0 carries nothing
    frame_append(hdr_len);
    repeat (skip) frame_append(8'($urandom));
  endtask

  task automatic frame_field(input int unsigned len, input logic [31:0] value);
    frame_append(ber_hdr_pkg::IntegerTag);
    frame_append(8'(len));
    for (int i = int'(len) - 1; i >= 0; i--) frame_append(value[8*i +: 8]);
  endtask

  task automatic add_random_field();
    frame_field($urandom_range(0, ber_hdr_pkg::MaxFieldBytes), $urandom);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_beat(frame_q[i], i == 0);
  endtask

  task automatic send_stray_bytes(input int unsigned n);
    repeat (n) send_beat(8'($urandom), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked frames: field extremes, both header forms, each framing error path.
  task automatic test_directed_frames();
    logic [7:0] bad_tag;
    send_stray_bytes(2);                       // nothing started yet: dropped

    frame_begin(8'h00);                        // every field zero length
    repeat (ber_hdr_pkg::NumFields) frame_field(0, '0);
    send_frame();

    frame_begin(ber_hdr_pkg::ShortFormMax);    // largest short form, all ones
    repeat (ber_hdr_pkg::NumFields) frame_field(4, 32'hFFFF_FFFF);
    send_frame();
    send_stray_bytes(2);                       // after a result: dropped

    frame_begin(8'h81);                        // long form, sign bits at each length
    frame_field(1, 32'h80);
    frame_field(2, 32'h8000);
    frame_field(3, 32'h80_0000);
    frame_field(4, 32'h8000_0000);
    frame_field(1, 32'h7F);
    frame_field(4, 32'h0102_0304);
    frame_field(1, 32'h80);
    frame_field(3, 32'h80_0001);
    send_frame();

    frame_begin(8'h83);
    repeat (6) add_random_field();
    frame_field(2, 32'h7FFF);
    frame_field(2, 32'h8000);
    send_frame();

    frame_begin(8'h10);                        // short form, no version tag
    frame_append(8'h30);
    send_frame();

    frame_begin(8'h82);                        // long form, no version tag
    frame_append(8'h04);
    send_frame();

    frame_begin(8'h00);                        // version longer than four bytes
    frame_append(ber_hdr_pkg::IntegerTag);
    frame_append(8'h05);
    send_frame();

    frame_begin(8'h05);                        // return code length of 255, over the maximum
    repeat (ber_hdr_pkg::NumFields - 1) add_random_field();
    frame_append(ber_hdr_pkg::IntegerTag);
    frame_append(8'hFF);
    send_frame();

    frame_begin(8'h00);                        // cut short, then a fresh start
    repeat (3) add_random_field();
    void'(frame_q.pop_back());
    send_frame();
    frame_begin(8'hFF);                        // longest skip pushes flow offset high
    repeat (ber_hdr_pkg::NumFields) frame_field(4, $urandom);
    send_frame();

    // missing tag at each field after the version; tag 0 and 255 included
    for (int k = 1; k < ber_hdr_pkg::NumFields; k++) begin
      frame_begin(8'($urandom_range(0, 128)));
      repeat (k) add_random_field();
      bad_tag = (k == 1) ? 8'h00 : (k == 2) ? 8'hFF : 8'($urandom_range(3, 255));
      frame_append(bad_tag);
      send_frame();
    end
  endtask

  // Version threshold either side of its boundary, extremes of the register.
  task automatic test_version_threshold();
    set_min_version(32'd5);
    frame_begin(8'h00);
    frame_field(1, 32'd4);
    repeat (ber_hdr_pkg::NumFields - 1) add_random_field();
    send_frame();
    frame_begin(8'h00);
    frame_field(1, 32'd5);
    repeat (ber_hdr_pkg::NumFields - 1) add_random_field();
    send_frame();

    set_min_version(32'hFFFF_FFFF);
    frame_begin(8'h84);
    frame_field(4, 32'hFFFF_FFFF);
    repeat (ber_hdr_pkg::NumFields - 1) add_random_field();
    send_frame();
    frame_begin(8'h00);
    frame_field(0, '0);
    send_frame();

    set_min_version(32'd1);                    // zero-length version is below one
    frame_begin(8'h00);
    frame_field(0, '0);
    send_frame();
  endtask

  // Mostly well-formed messages with random content; the rest are damaged.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pos;
    logic [7:0]  hdr_len;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 1)) hdr_len = 8'($urandom_range(0, 128));
      else if ($urandom_range(0, 7) != 0) hdr_len = 8'($urandom_range(129, 136));
      else hdr_len = 8'($urandom_range(137, 255));
      frame_begin(hdr_len);
      // half the versions sit right at the threshold
      if ($urandom_range(0, 1))
        frame_field(4, min_version_model + 32'($urandom_range(0, 2)) - 32'd1);
      else
        add_random_field();
      repeat (ber_hdr_pkg::NumFields - 1) add_random_field();

      if ($urandom_range(0, 3) == 0) begin
        pos = $urandom_range(2, frame_q.size() - 1);
        case ($urandom_range(0, 4))
          0: frame_q[pos] = 8'($urandom);
          1: frame_q[pos] = 8'($urandom_range(5, 255));
          2: while (frame_q.size() > pos) void'(frame_q.pop_back());
          3: frame_q.insert(pos, 8'($urandom));
          default: for (int i = pos; i < frame_q.size(); i++) frame_q[i] = 8'($urandom);
        endcase
      end
      send_frame();
      sent += frame_q.size();
      if ($urandom_range(0, 7) == 0) send_stray_bytes($urandom_range(1, 3));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    message_start_i = 1'b0;
    gaps_on         = 1'b1;
    mismatch_count  = 0;
    results_checked = 0;
    beats_sent      = 0;
    settings_used   = 0;
    min_version_model = ber_hdr_pkg::MinVersionReset;
    hdr_phase       = ber_hdr_pkg::PH_IDLE;
    field_sel       = ber_hdr_pkg::FieldVersion;
    byte_pos        = '0;
    count_left      = '0;
    value_len       = '0;
    long_hdr        = 1'b0;
    value_acc       = '0;
    flow_hold       = '0;
    foreach (field_vals[i]) field_vals[i] = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_frames();
    test_version_threshold();

    set_min_version(32'd0);
    test_random_traffic(250);
    set_min_version(32'h8000_0000);
    test_random_traffic(250);
    set_min_version($urandom);
    test_random_traffic(200);
    set_min_version(32'hFFFF_FFFF);
    test_random_traffic(150);
    set_min_version(32'($urandom_range(0, 255)));
    gaps_on = 1'b0;                            // closing stretch at full rate
    test_random_traffic(200);

    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d byte beats under %0d min_version settings", beats_sent, settings_used);
    $display("Checked %0d header results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0 && decoded_headers_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/ber_hdr_pkg.sv
design/ber_integer_header_parser_core.sv
tb/tb.sv
